// ===== design/rws_pkg.sv =====
// Shared package of the roulette wheel selector: field widths, request codes,
// controller state encoding and the command/status structs.
// No dependencies.
`default_nettype none

package rws_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_ENTRIES_DEF = 64;
   localparam int WEIGHT_BITS_DEF = 24;

   // Fixed field widths of the stream payloads
   localparam int FRAC_BITS     = 24;
   localparam int ENTRY_BITS    = 6;
   localparam int WVAL_BITS     = 24;
   localparam int POP_BITS      = 7;
   localparam int REQ_DATA_BITS = 56;
   localparam int RSP_DATA_BITS = 8;

   localparam logic [POP_BITS-1:0] POP_RESET = 7'd64;

   // Request kinds carried on req_tuser
   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_DRAW  = 1'b1
   } req_kind_type;

   // Controller states, one-hot
   typedef enum logic [7:0] {
      ST_CLEAR     = 8'b0000_0001,
      ST_IDLE      = 8'b0000_0010,
      ST_WR_READ   = 8'b0000_0100,
      ST_WR_UPDATE = 8'b0000_1000,
      ST_MUL_LO    = 8'b0001_0000,
      ST_MUL_HI    = 8'b0010_0000,
      ST_SCAN      = 8'b0100_0000,
      ST_FINISH    = 8'b1000_0000
   } ctrl_state_type;

   typedef struct packed {
      logic clear_en;
      logic capture;
      logic wr_read;
      logic wr_commit;
      logic mul_lo;
      logic mul_hi;
      logic scan_en;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic total_zero;
      logic frac_zero;
      logic scan_done;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/roulette_wheel_selector_unit.sv =====
// Top level of the roulette wheel selector: stream ports, controller and
// datapath. Depends on rws_pkg, rws_ctrl and rws_datapath.
//
//   channel   direction  handshake                 payload
//   req_      in         req_tvalid / req_tready   tdata, tuser (request kind)
//   rsp_      out        rsp_tvalid / rsp_tready   tdata, tuser (no_weight flag)
//   csr_      in         csr_valid  / csr_ready    csr_data (population_count)
//
// A write transaction steps through accept, read old weight and update total.
// A draw steps through accept, two multiply steps, a scan and result load. The
// scan reads the weight memory through its single read port, feeding the running
// sum one entry a cycle up to the active population; an empty wheel or a zero
// fraction skips the scan.
// After reset a clearing pass zeroes the memory; req_tready stays low meanwhile,
// csr writes are taken at all times.
// A finished result waits in the rsp register; a stalled rsp side holds the next
// draw at its last step and every request behind it, earlier writes keep flowing.
`default_nettype none

module roulette_wheel_selector_unit import rws_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request stream
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // [5:0] entry_index, [29:6] weight_value, [53:30] random_fraction, [55:54] zero
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // [0] req_type
   input  wire logic                     req_tuser,
   // result stream
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // [5:0] selected_index, [7:6] zero
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   // [0] no_weight
   output logic                          rsp_tuser,
   // population_count register write
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [POP_BITS-1:0]      csr_data
);

   localparam int W_LO = ENTRY_BITS;
   localparam int F_LO = ENTRY_BITS + WVAL_BITS;

   dp_cmd_type            cmd;
   dp_status_type         status;
   logic [ENTRY_BITS-1:0] rsp_index;

   // configuration is always taken
   assign csr_ready = 1'b1;

   rws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   rws_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_entry     (req_tdata[ENTRY_BITS-1:0]),
      .req_weight    (req_tdata[W_LO +: WVAL_BITS]),
      .req_frac      (req_tdata[F_LO +: FRAC_BITS]),
      .csr_we        (csr_valid && csr_ready),
      .csr_pop       (csr_data),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_index     (rsp_index),
      .rsp_no_weight (rsp_tuser)
   );

   // pad the index to whole bytes
   assign rsp_tdata = RSP_DATA_BITS'(rsp_index);

endmodule

`default_nettype wire

// ===== design/rws_ctrl.sv =====
// Controller of the roulette wheel selector: clearing pass, write sequence,
// draw sequence and result hand-off. Depends on rws_pkg.
`default_nettype none

module rws_ctrl import rws_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_kind,
   output logic               req_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_kind == REQ_DRAW) ? ST_MUL_LO : ST_WR_READ;
            end
         end
         ST_WR_READ: begin
            cmd.wr_read = 1'b1;
            state_in    = ST_WR_UPDATE;
         end
         ST_WR_UPDATE: begin
            cmd.wr_commit = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            // empty wheel or zero fraction: answer index 0 without a scan
            state_in = (status.total_zero || status.frac_zero) ? ST_FINISH : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/rws_datapath.sv =====
// Datapath of the roulette wheel selector: weight memory, running total,
// target multiplier, scan accumulator and result register. Depends on rws_pkg.
`default_nettype none

module rws_datapath import rws_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire dp_cmd_type               cmd,
   output dp_status_type                 status,
   input  wire logic [ENTRY_BITS-1:0]    req_entry,
   input  wire logic [WVAL_BITS-1:0]     req_weight,
   input  wire logic [FRAC_BITS-1:0]     req_frac,
   input  wire logic                     csr_we,
   input  wire logic [POP_BITS-1:0]      csr_pop,
   input  wire logic                     rsp_ready,
   output logic                          rsp_valid,
   output logic [ENTRY_BITS-1:0]         rsp_index,
   output logic                          rsp_no_weight
);

   localparam int IDX_BITS   = $clog2(MAX_ENTRIES);
   localparam int TOTAL_BITS = WEIGHT_BITS + IDX_BITS;
   localparam int HI_BITS    = (TOTAL_BITS > FRAC_BITS) ? TOTAL_BITS - FRAC_BITS : 1;
   localparam int PAD_BITS   = HI_BITS + FRAC_BITS;
   localparam int PROD_BITS  = 2 * FRAC_BITS;
   localparam int CNT_BITS   = 11;
   localparam logic [CNT_BITS-1:0] MAX_CNT  = CNT_BITS'(MAX_ENTRIES);
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(MAX_ENTRIES - 1);

   logic [WEIGHT_BITS-1:0] mem [MAX_ENTRIES];
   logic [WEIGHT_BITS-1:0] rdata_ff;

   logic [ENTRY_BITS-1:0]  entry_ff;
   logic [WVAL_BITS-1:0]   weight_ff;
   logic [FRAC_BITS-1:0]   frac_ff;
   logic [POP_BITS-1:0]    pop_ff;
   logic [TOTAL_BITS-1:0]  total_ff;
   logic [IDX_BITS-1:0]    clr_addr_ff;
   logic [PROD_BITS-1:0]   prod_ff;
   logic [TOTAL_BITS-1:0]  target_ff;
   logic [TOTAL_BITS-1:0]  sum_ff;
   logic [IDX_BITS-1:0]    scan_addr_ff;
   logic [IDX_BITS-1:0]    chk_idx_ff;
   logic                   rd_valid_ff;
   logic [IDX_BITS-1:0]    pick_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_BITS-1:0]  rsp_index_ff;
   logic                   rsp_nw_ff;

   logic [IDX_BITS-1:0]    entry_addr;
   logic                   entry_ok;
   logic [WEIGHT_BITS-1:0] wval;
   logic [IDX_BITS-1:0]    rd_addr;
   logic [PAD_BITS-1:0]    total_pad;
   logic [FRAC_BITS-1:0]   mul_a;
   logic [PROD_BITS-1:0]   prod;
   logic [PROD_BITS:0]     tgt_sum;
   logic [TOTAL_BITS-1:0]  new_sum;
   logic [CNT_BITS-1:0]    pop_ext;
   logic [CNT_BITS-1:0]    active;
   logic [IDX_BITS-1:0]    last_idx;
   logic                   hit;
   logic                   at_last;

   assign entry_addr = IDX_BITS'(entry_ff);
   assign entry_ok   = CNT_BITS'(entry_ff) < MAX_CNT;
   assign wval       = WEIGHT_BITS'(weight_ff);

   // active population, clamped to 1 .. MAX_ENTRIES
   assign pop_ext = CNT_BITS'(pop_ff);
   always_comb begin
      priority if (pop_ext == '0) begin
         active = CNT_BITS'(1);
      end else if (pop_ext > MAX_CNT) begin
         active = MAX_CNT;
      end else begin
         active = pop_ext;
      end
   end
   assign last_idx = IDX_BITS'(active - CNT_BITS'(1));

   // target = hi*frac + ((lo*frac) >> FRAC_BITS), one shared multiplier
   assign total_pad = PAD_BITS'(total_ff);
   assign mul_a     = cmd.mul_hi ? FRAC_BITS'(total_pad[PAD_BITS-1:FRAC_BITS])
                                 : total_pad[FRAC_BITS-1:0];
   assign prod      = mul_a * frac_ff;
   assign tgt_sum   = {1'b0, prod} + {1'b0, prod_ff >> FRAC_BITS};

   assign new_sum = sum_ff + TOTAL_BITS'(rdata_ff);
   assign hit     = new_sum > target_ff;
   assign at_last = chk_idx_ff == last_idx;

   assign rd_addr = cmd.scan_en ? scan_addr_ff : entry_addr;

   // weight memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         mem[clr_addr_ff] <= '0;
      end else if (cmd.wr_commit && entry_ok) begin
         mem[entry_addr] <= wval;
      end
      if (cmd.wr_read || cmd.scan_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pop_ff       <= POP_RESET;
         total_ff     <= '0;
         clr_addr_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            pop_ff <= csr_pop;
         end
         if (cmd.clear_en) begin
            clr_addr_ff <= clr_addr_ff + IDX_BITS'(1);
         end
         if (cmd.wr_commit && entry_ok) begin
            total_ff <= total_ff - TOTAL_BITS'(rdata_ff) + TOTAL_BITS'(wval);
         end
         if (cmd.mul_lo) begin
            rd_valid_ff <= 1'b0;
         end else if (cmd.scan_en) begin
            rd_valid_ff <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         entry_ff  <= req_entry;
         weight_ff <= req_weight;
         frac_ff   <= req_frac;
      end
      if (cmd.mul_lo) begin
         prod_ff      <= prod;
         sum_ff       <= '0;
         scan_addr_ff <= '0;
         pick_ff      <= '0;
      end
      if (cmd.mul_hi) begin
         target_ff <= tgt_sum[TOTAL_BITS-1:0];
      end
      if (cmd.scan_en) begin
         scan_addr_ff <= scan_addr_ff + IDX_BITS'(1);
         chk_idx_ff   <= scan_addr_ff;
         if (rd_valid_ff) begin
            sum_ff <= new_sum;
            if (hit || at_last) begin
               pick_ff <= chk_idx_ff;
            end
         end
      end
      if (cmd.load_rsp) begin
         rsp_index_ff <= (total_ff == '0) ? '0 : ENTRY_BITS'(pick_ff);
         rsp_nw_ff    <= total_ff == '0;
      end
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);

   assign status.clear_done = clr_addr_ff == LAST_IDX;
   assign status.total_zero = total_ff == '0;
   assign status.frac_zero  = frac_ff == '0;
   assign status.scan_done  = cmd.scan_en && rd_valid_ff && (hit || at_last);
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_index     = rsp_index_ff;
   assign rsp_no_weight = rsp_nw_ff;

endmodule

`default_nettype wire
